// File: sv/somr_pkg.sv
// Shared types and constants for the spiral order matrix reader.
`default_nettype none

package somr_pkg;

    localparam int DATA_W      = 32;
    localparam int DIM_W       = 4;
    localparam int TOTAL_W     = 2 * DIM_W;
    localparam int CFG_IDX_W   = 1;
    localparam int DEF_MAX_ROWS = 8;
    localparam int DEF_MAX_COLS = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // one pending spiral burst
    typedef struct packed {
        logic [DIM_W-1:0]   rows;
        logic [DIM_W-1:0]   cols;
        logic [TOTAL_W-1:0] total;
    } cmd_t;

endpackage

`default_nettype wire

// File: sv/somr_front.sv
// Front end: configuration registers, element loading and burst command issue.
`default_nettype none

module somr_front #(
    parameter int MAX_ROWS = somr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = somr_pkg::DEF_MAX_COLS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [somr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [somr_pkg::DIM_W-1:0]      cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [somr_pkg::DATA_W-1:0]     element_value,
    output logic                                 wr_en,
    output logic [((MAX_ROWS*MAX_COLS) > 1 ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] wr_addr,
    output logic [somr_pkg::DATA_W-1:0]          wr_data,
    output logic                                 cmd_push,
    output somr_pkg::cmd_t                       cmd,
    input  wire logic                            cmd_full,
    input  wire logic                            burst_done
);

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int AW      = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int CMPW    = CW > somr_pkg::TOTAL_W ? CW : somr_pkg::TOTAL_W;
    localparam int DIM_MAX = (1 << somr_pkg::DIM_W) - 1;
    localparam int ROW_LIM = MAX_ROWS < DIM_MAX ? MAX_ROWS : DIM_MAX;
    localparam int COL_LIM = MAX_COLS < DIM_MAX ? MAX_COLS : DIM_MAX;
    localparam logic [somr_pkg::DIM_W-1:0] ROW_LIM_V = somr_pkg::DIM_W'(ROW_LIM);
    localparam logic [somr_pkg::DIM_W-1:0] COL_LIM_V = somr_pkg::DIM_W'(COL_LIM);
    localparam logic [somr_pkg::DIM_W-1:0] DIM_ONE   = somr_pkg::DIM_W'(1);

    logic [somr_pkg::DIM_W-1:0]   row_count_reg;
    logic [somr_pkg::DIM_W-1:0]   column_count_reg;
    logic [CW-1:0]                load_count_reg;
    logic [CW-1:0]                load_count_next;
    logic                         busy_reg;
    logic                         busy_next;
    logic [somr_pkg::DIM_W-1:0]   rows;
    logic [somr_pkg::DIM_W-1:0]   cols;
    logic [somr_pkg::TOTAL_W-1:0] total;
    logic                         accept;
    logic                         matrix_end;

    // clamp dimensions into the supported range
    always_comb
    begin
        if (row_count_reg == '0)
            rows = DIM_ONE;
        else if (row_count_reg > ROW_LIM_V)
            rows = ROW_LIM_V;
        else
            rows = row_count_reg;

        if (column_count_reg == '0)
            cols = DIM_ONE;
        else if (column_count_reg > COL_LIM_V)
            cols = COL_LIM_V;
        else
            cols = column_count_reg;
    end

    assign total = somr_pkg::TOTAL_W'(rows) * somr_pkg::TOTAL_W'(cols);

    // hold input while a burst still reads the store or the command queue is full
    assign in_stall   = busy_reg || cmd_full;
    assign accept     = in_valid && !in_stall;
    assign matrix_end = CMPW'(load_count_reg + CW'(1)) == CMPW'(total);

    assign wr_en   = accept;
    assign wr_addr = load_count_reg[AW-1:0];
    assign wr_data = element_value;

    assign cmd_push   = accept && matrix_end;
    assign cmd.rows   = rows;
    assign cmd.cols   = cols;
    assign cmd.total  = total;

    always_comb
    begin
        load_count_next = load_count_reg;
        busy_next       = busy_reg;
        if (burst_done)
            busy_next = 1'b0;
        if (cfg_we)
        begin
            load_count_next = '0;
        end
        else if (accept)
        begin
            if (matrix_end)
            begin
                load_count_next = '0;
                busy_next       = 1'b1;
            end
            else
            begin
                load_count_next = load_count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= somr_pkg::DIM_RESET;
            column_count_reg <= somr_pkg::DIM_RESET;
            load_count_reg   <= '0;
            busy_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    somr_pkg::REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                    somr_pkg::REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                    default: ;
                endcase
            end
            load_count_reg <= load_count_next;
            busy_reg       <= busy_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/somr_cmd_queue.sv
// Two-entry command queue between the load front end and the spiral back end.
`default_nettype none

module somr_cmd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  somr_pkg::cmd_t       push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output somr_pkg::cmd_t       head_cmd,
    output logic                 not_empty
);

    somr_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           do_push;
    logic           do_pop;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head_cmd  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

`default_nettype wire

// File: sv/somr_back.sv
// Back end: matrix store, spiral address walker and output buffer.
`default_nettype none

module somr_back #(
    parameter int MAX_ROWS = somr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = somr_pkg::DEF_MAX_COLS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic [((MAX_ROWS*MAX_COLS) > 1 ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] wr_addr,
    input  wire logic [somr_pkg::DATA_W-1:0]  wr_data,
    input  somr_pkg::cmd_t                    cmd,
    input  wire logic                         cmd_valid,
    output logic                              cmd_pop,
    output logic                              burst_done,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [somr_pkg::DATA_W-1:0]       out_value,
    output logic                              last_of_run
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int DW    = somr_pkg::DIM_W;
    localparam int TW    = somr_pkg::TOTAL_W;

    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    logic [somr_pkg::DATA_W-1:0] mem [DEPTH];
    logic [somr_pkg::DATA_W-1:0] rd_data_reg;
    logic                        inflight_reg;
    logic                        last_pend_reg;

    logic          active_reg, active_next;
    logic [1:0]    dir_reg, dir_next;
    logic [DW-1:0] r_reg, r_next;
    logic [DW-1:0] c_reg, c_next;
    logic [DW-1:0] top_reg, top_next;
    logic [DW-1:0] bottom_reg, bottom_next;
    logic [DW-1:0] left_reg, left_next;
    logic [DW-1:0] right_reg, right_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] stride_reg, stride_next;
    logic [TW-1:0] rem_reg, rem_next;

    logic [somr_pkg::DATA_W-1:0] fifo_value [2];
    logic                        fifo_last [2];
    logic                        fifo_wr_reg;
    logic                        fifo_rd_reg;
    logic [1:0]                  fifo_count_reg;
    logic                        out_pop;
    logic [1:0]                  occupancy;
    logic                        rd_en;
    logic                        final_read;

    // issue a read only if its data has a free buffer slot on arrival
    assign out_pop    = out_valid && !out_stall;
    assign occupancy  = fifo_count_reg + {1'b0, inflight_reg} - {1'b0, out_pop};
    assign rd_en      = active_reg && (occupancy < 2'd2);
    assign final_read = rem_reg == TW'(1);
    assign cmd_pop    = !active_reg && cmd_valid;
    assign burst_done = rd_en && final_read;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg   <= mem[addr_reg];
            last_pend_reg <= final_read;
        end
    end

    // spiral walk: run along an edge, then shrink the bound and turn clockwise
    always_comb
    begin
        active_next = active_reg;
        dir_next    = dir_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        top_next    = top_reg;
        bottom_next = bottom_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        addr_next   = addr_reg;
        stride_next = stride_reg;
        rem_next    = rem_reg;
        if (cmd_pop)
        begin
            active_next = 1'b1;
            dir_next    = DIR_RIGHT;
            r_next      = '0;
            c_next      = '0;
            top_next    = '0;
            left_next   = '0;
            bottom_next = cmd.rows - DW'(1);
            right_next  = cmd.cols - DW'(1);
            addr_next   = '0;
            stride_next = AW'(cmd.cols);
            rem_next    = cmd.total;
        end
        else if (rd_en)
        begin
            rem_next = rem_reg - TW'(1);
            if (final_read)
            begin
                active_next = 1'b0;
            end
            else
            begin
                case (dir_reg)
                    DIR_RIGHT:
                    begin
                        if (c_reg < right_reg)
                        begin
                            c_next    = c_reg + DW'(1);
                            addr_next = addr_reg + AW'(1);
                        end
                        else
                        begin
                            top_next  = top_reg + DW'(1);
                            dir_next  = DIR_DOWN;
                            r_next    = r_reg + DW'(1);
                            addr_next = addr_reg + stride_reg;
                        end
                    end
                    DIR_DOWN:
                    begin
                        if (r_reg < bottom_reg)
                        begin
                            r_next    = r_reg + DW'(1);
                            addr_next = addr_reg + stride_reg;
                        end
                        else
                        begin
                            right_next = right_reg - DW'(1);
                            dir_next   = DIR_LEFT;
                            c_next     = c_reg - DW'(1);
                            addr_next  = addr_reg - AW'(1);
                        end
                    end
                    DIR_LEFT:
                    begin
                        if (c_reg > left_reg)
                        begin
                            c_next    = c_reg - DW'(1);
                            addr_next = addr_reg - AW'(1);
                        end
                        else
                        begin
                            bottom_next = bottom_reg - DW'(1);
                            dir_next    = DIR_UP;
                            r_next      = r_reg - DW'(1);
                            addr_next   = addr_reg - stride_reg;
                        end
                    end
                    DIR_UP:
                    begin
                        if (r_reg > top_reg)
                        begin
                            r_next    = r_reg - DW'(1);
                            addr_next = addr_reg - stride_reg;
                        end
                        else
                        begin
                            left_next = left_reg + DW'(1);
                            dir_next  = DIR_RIGHT;
                            c_next    = c_reg + DW'(1);
                            addr_next = addr_reg + AW'(1);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg    <= dir_next;
        r_reg      <= r_next;
        c_reg      <= c_next;
        top_reg    <= top_next;
        bottom_reg <= bottom_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        addr_reg   <= addr_next;
        stride_reg <= stride_next;
        if (inflight_reg)
        begin
            fifo_value[fifo_wr_reg] <= rd_data_reg;
            fifo_last[fifo_wr_reg]  <= last_pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            rem_reg        <= '0;
            inflight_reg   <= 1'b0;
            fifo_wr_reg    <= 1'b0;
            fifo_rd_reg    <= 1'b0;
            fifo_count_reg <= 2'd0;
        end
        else
        begin
            active_reg   <= active_next;
            rem_reg      <= rem_next;
            inflight_reg <= rd_en;
            if (inflight_reg)
                fifo_wr_reg <= !fifo_wr_reg;
            if (out_pop)
                fifo_rd_reg <= !fifo_rd_reg;
            fifo_count_reg <= fifo_count_reg + {1'b0, inflight_reg} - {1'b0, out_pop};
        end
    end

    assign out_valid   = fifo_count_reg != 2'd0;
    assign out_value   = fifo_value[fifo_rd_reg];
    assign last_of_run = fifo_last[fifo_rd_reg];

endmodule

`default_nettype wire

// File: sv/spiral_order_matrix_reader_top.sv
// After the last element is taken, its command passes the queue to the walker; each read is registered, then buffered.
// Throughput: one element loaded per cycle while in_stall is low, one result per cycle while out_stall is low;
// the matrix store has one read port, so the results of a burst are read one after another.
// Input is held from the last element until the final read of the burst is issued,
// so the next matrix does not overwrite the store before the burst has read it.
// Reset: rst_n clears counters, queue and buffers and sets both dimensions to 8.
`default_nettype none

module spiral_order_matrix_reader_top #(
    parameter int MAX_ROWS = somr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = somr_pkg::DEF_MAX_COLS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [somr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [somr_pkg::DIM_W-1:0]      cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic signed [somr_pkg::DATA_W-1:0] element_value,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [somr_pkg::DATA_W-1:0]   out_value,
    output logic                                 last_of_run
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [somr_pkg::DATA_W-1:0] wr_data;
    logic                        cmd_push;
    somr_pkg::cmd_t              push_cmd;
    logic                        cmd_full;
    logic                        cmd_pop;
    somr_pkg::cmd_t              head_cmd;
    logic                        cmd_valid;
    logic                        burst_done;
    logic [somr_pkg::DATA_W-1:0] out_word;

    somr_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .element_value (element_value),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .cmd_push      (cmd_push),
        .cmd           (push_cmd),
        .cmd_full      (cmd_full),
        .burst_done    (burst_done)
    );

    somr_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_cmd  (push_cmd),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .head_cmd  (head_cmd),
        .not_empty (cmd_valid)
    );

    somr_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .cmd         (head_cmd),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .burst_done  (burst_done),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_value   (out_word),
        .last_of_run (last_of_run)
    );

    assign out_value = out_word;

endmodule

`default_nettype wire
